>>> design/tfc_pkg.sv
// shared types and constants of the triangle frustum classifier
package tfc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned ProdW  = 2 * CoordW;
  localparam int unsigned DotW   = ProdW + 2;
  localparam int unsigned PlainW = DotW + 1;
  localparam int unsigned LoW    = CoordW + 1;
  localparam int unsigned HiW    = DotW - LoW;
  localparam int unsigned LoPW   = LoW + 1 + CoordW;
  localparam int unsigned HiPW   = HiW + CoordW;
  localparam int unsigned ScaleW = DotW + CoordW + 1;
  localparam int unsigned InDataW  = 328;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TRI   = 2'd1,
    REQ_PRISM = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    VERD_CONTAINS   = 2'd0,
    VERD_INTERSECTS = 2'd1,
    VERD_OUTSIDE    = 2'd2
  } verdict_e;

endpackage

>>> design/triangle_frustum_classifier.sv
// triangle frustum classifier: plane store, distance pipeline and verdict
//
// input beats on s_axis carry a request kind in tuser and plane index, three
// vertices and the prism height in tdata. a load beat writes one plane and
// gives no output beat; a triangle or prism check gives one verdict beat on
// m_axis (0 contains, 1 intersects, 2 outside). request kind 3 and loads to
// a slot at or above NUM_PLANES are dropped.
// a check beat moves through the stage 1, 2 and 3 registers into the
// output register; one beat per cycle is sustained unless m_axis stalls. the
// pipeline is: products of all planes and vertices, distance sums with the
// plain sign test, selection of the first fully rejecting plane with the
// split height products, and the scaled sign test into the output register.
// loads land in the plane store at the accepting edge, so a check sees every
// load accepted before it. the plane store has no reset; checks must follow
// the loads of all planes. reset empties the pipeline.
// when m_axis stalls the whole pipeline holds and s_axis tready drops.
module triangle_frustum_classifier
  import tfc_pkg::*;
#(
  parameter int unsigned NUM_PLANES = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // plane_index, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, prism_scale
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // verdict
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic en;
  logic in_acc;
  logic [IdxW-1:0] in_idx;
  logic signed [CoordW-1:0] in_v [3][3];
  logic signed [CoordW-1:0] in_h;

  logic signed [CoordW-1:0] plane_q [NUM_PLANES][4];

  // stage 1
  logic s1_valid_q, s1_valid_d;
  req_e s1_req_q;
  logic signed [CoordW-1:0] s1_h_q;
  logic signed [ProdW-1:0] s1_prod_q [NUM_PLANES][3][3];
  logic signed [ProdW-1:0] s1_prod_d [NUM_PLANES][3][3];
  logic signed [CoordW-1:0] s1_d_q [NUM_PLANES];

  // stage 2
  logic s2_valid_q;
  req_e s2_req_q;
  logic signed [CoordW-1:0] s2_h_q;
  logic signed [DotW-1:0] s2_dot_q [NUM_PLANES][3];
  logic signed [DotW-1:0] s2_dot_d [NUM_PLANES][3];
  logic [2:0] s2_rej_q [NUM_PLANES];
  logic [2:0] s2_rej_d [NUM_PLANES];
  logic signed [CoordW-1:0] s2_d_q [NUM_PLANES];

  // stage 3
  logic s3_valid_q;
  req_e s3_req_q;
  logic s3_all_q, s3_all_d;
  logic s3_any_q, s3_any_d;
  logic signed [LoPW-1:0] s3_lo_q [3];
  logic signed [LoPW-1:0] s3_lo_d [3];
  logic signed [HiPW-1:0] s3_hi_q [3];
  logic signed [HiPW-1:0] s3_hi_d [3];
  logic signed [CoordW-1:0] s3_d_q, s3_d_d;

  // output register
  logic out_valid_q, out_valid_d;
  verdict_e out_verd_q, out_verd_d;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign in_acc        = s_axis_tvalid && en;
  assign in_idx        = s_axis_tdata[IdxW-1:0];
  assign in_h          = s_axis_tdata[IdxW+9*CoordW +: CoordW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        in_v[k][j] = s_axis_tdata[IdxW+CoordW*(3*k+j) +: CoordW];
      end
    end
  end

  // plane store, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && req_e'(s_axis_tuser) == REQ_LOAD) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (32'(in_idx) == p) begin
          plane_q[p][0] <= in_v[0][0];
          plane_q[p][1] <= in_v[0][1];
          plane_q[p][2] <= in_v[0][2];
          plane_q[p][3] <= in_v[1][0];
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          s1_prod_d[p][k][j] = plane_q[p][j] * in_v[k][j];
        end
      end
    end
    s1_valid_d = in_acc && (req_e'(s_axis_tuser) == REQ_TRI ||
                            req_e'(s_axis_tuser) == REQ_PRISM);
  end

  // distance sums and plain sign test
  always_comb begin
    logic signed [PlainW-1:0] plain;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < 3; k++) begin
        s2_dot_d[p][k] = DotW'(s1_prod_q[p][k][0]) + DotW'(s1_prod_q[p][k][1])
                       + DotW'(s1_prod_q[p][k][2]);
        plain = PlainW'(s2_dot_d[p][k]) + (PlainW'(s1_d_q[p]) <<< 16);
        s2_rej_d[p][k] = plain[PlainW-1];
      end
    end
  end

  // first fully rejecting plane, split height products
  always_comb begin
    logic signed [DotW-1:0] sel_dot [3];
    logic found;
    found    = 1'b0;
    s3_any_d = 1'b0;
    s3_d_d   = '0;
    for (int k = 0; k < 3; k++) sel_dot[k] = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (!found) begin
        s3_any_d = s3_any_d || (|s2_rej_q[p]);
        if (&s2_rej_q[p]) begin
          found  = 1'b1;
          s3_d_d = s2_d_q[p];
          for (int k = 0; k < 3; k++) sel_dot[k] = s2_dot_q[p][k];
        end
      end
    end
    s3_all_d = found;
    for (int k = 0; k < 3; k++) begin
      s3_lo_d[k] = $signed({1'b0, sel_dot[k][LoW-1:0]}) * s2_h_q;
      s3_hi_d[k] = $signed(sel_dot[k][DotW-1:LoW]) * s2_h_q;
    end
  end

  // scaled sign test and verdict
  always_comb begin
    logic signed [ScaleW-1:0] scaled;
    logic all_scaled;
    all_scaled = 1'b1;
    for (int k = 0; k < 3; k++) begin
      scaled = (ScaleW'(s3_hi_q[k]) <<< LoW) + ScaleW'(s3_lo_q[k])
             + (ScaleW'(s3_d_q) <<< 32);
      all_scaled = all_scaled && scaled[ScaleW-1];
    end
    if (s3_all_q) begin
      if (s3_req_q == REQ_PRISM && !all_scaled) begin
        out_verd_d = VERD_INTERSECTS;
      end else begin
        out_verd_d = VERD_OUTSIDE;
      end
    end else if (s3_any_q) begin
      out_verd_d = VERD_INTERSECTS;
    end else begin
      out_verd_d = VERD_CONTAINS;
    end
    out_valid_d = s3_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_req_q   <= req_e'(s_axis_tuser);
      s1_h_q     <= in_h;
      s1_prod_q  <= s1_prod_d;
      for (int p = 0; p < NUM_PLANES; p++) s1_d_q[p] <= plane_q[p][3];
      s2_req_q   <= s1_req_q;
      s2_h_q     <= s1_h_q;
      s2_dot_q   <= s2_dot_d;
      s2_rej_q   <= s2_rej_d;
      s2_d_q     <= s1_d_q;
      s3_req_q   <= s2_req_q;
      s3_all_q   <= s3_all_d;
      s3_any_q   <= s3_any_d;
      s3_lo_q    <= s3_lo_d;
      s3_hi_q    <= s3_hi_d;
      s3_d_q     <= s3_d_d;
      out_verd_q <= out_verd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW-2)'(0), out_verd_q};

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOAD |=> !s1_valid_q)
    else $error("load beat entered the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && s3_valid_q |=> s3_valid_q && out_valid_q)
    else $error("pipeline moved during a stall");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("invalid verdict code");

endmodule

>>> tb/sv/triangle_frustum_classifier_tb.sv
// self-checking testbench of the triangle frustum classifier
module triangle_frustum_classifier_tb;
  import tfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPlanes = 6;
  localparam int unsigned IdleLimit = 2000;

  typedef struct {
    req_e            kind;
    logic [2:0]      slot;
    logic [31:0]     crd[10];  // nine vertex coordinates then prism scale
  } req_t;

  class verdict_board;
    logic signed [31:0] pa[NumPlanes], pb[NumPlanes], pc[NumPlanes], pd[NumPlanes];
    verdict_e           pending[$];
    int                 errors;
    int                 checked;

    function void note_beat(req_t r);
      logic signed [31:0] v[3][3];
      logic signed [31:0] h;
      logic signed [67:0] dot;
      logic signed [111:0] sdist;
      int                 rej, srej;
      verdict_e           verd;
      if (r.kind == REQ_LOAD) begin
        if (r.slot < NumPlanes) begin
          pa[r.slot] = r.crd[0];
          pb[r.slot] = r.crd[1];
          pc[r.slot] = r.crd[2];
          pd[r.slot] = r.crd[3];
        end
        return;
      end
      if (r.kind != REQ_TRI && r.kind != REQ_PRISM) return;
      for (int k = 0; k < 9; k++) v[k / 3][k % 3] = r.crd[k];
      h = r.crd[9];
      verd = VERD_CONTAINS;
      for (int p = 0; p < NumPlanes; p++) begin
        rej = 0;
        for (int k = 0; k < 3; k++) begin
          dot = 68'(pa[p]) * v[k][0] + 68'(pb[p]) * v[k][1] + 68'(pc[p]) * v[k][2];
          if (dot + (68'(pd[p]) <<< 16) < 0) rej++;
        end
        if (rej == 3) begin
          if (r.kind == REQ_TRI) verd = VERD_OUTSIDE;
          else begin
            srej = 0;
            for (int k = 0; k < 3; k++) begin
              dot = 68'(pa[p]) * v[k][0] + 68'(pb[p]) * v[k][1] + 68'(pc[p]) * v[k][2];
              sdist = 112'(dot) * 112'(h) + (112'(pd[p]) <<< 32);
              if (sdist < 0) srej++;
            end
            verd = (srej == 3) ? VERD_OUTSIDE : VERD_INTERSECTS;
          end
          break;
        end
        if (rej > 0) verd = VERD_INTERSECTS;
      end
      pending = {pending, verd};
    endfunction

    function void check_beat(logic [OutDataW-1:0] got);
      verdict_e want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: verdict beat with nothing expected, actual %0d", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== OutDataW'(want)) begin
        $display("%0t: verdict mismatch, expected %0d actual %0d", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  verdict_board board = new();
  int  idle_cycles;
  int  sent;
  bit  stim_done;

  triangle_frustum_classifier #(.NUM_PLANES(NumPlanes)) dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // after an optional random gap, pack and hold one beat until accepted, returns at the next falling edge
  task automatic send_beat(req_t r);
    logic [InDataW-1:0] d;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    d = '0;
    d[2:0] = r.slot;
    for (int k = 0; k < 10; k++) d[3 + 32 * k +: 32] = r.crd[k];
    s_axis_tdata  <= d;
    s_axis_tuser  <= r.kind;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_beat(r);
    sent++;
    @(negedge clk_i);
  endtask

  // drop tvalid after the last beat of a burst
  task automatic idle_bus();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 8)) - 4) <<< 16 : 32'd0;
      3: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000) <<< 8;
      default: return $urandom();
    endcase
  endfunction

  function automatic req_t rand_check();
    req_t r;
    r.kind = $urandom_range(0, 1) ? REQ_TRI : REQ_PRISM;
    r.slot = 3'($urandom_range(0, 7));
    for (int k = 0; k < 10; k++) r.crd[k] = rand_coord();
    return r;
  endfunction

  function automatic req_t plane_load(int slot, logic [31:0] a, logic [31:0] b,
                                      logic [31:0] c, logic [31:0] d);
    req_t r;
    r.kind = REQ_LOAD;
    r.slot = 3'(slot);
    for (int k = 0; k < 10; k++) r.crd[k] = $urandom();
    r.crd[0] = a; r.crd[1] = b; r.crd[2] = c; r.crd[3] = d;
    return r;
  endfunction

  // result side with random stalls
  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      board.check_beat(m_axis_tdata);
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else if (!stim_done || board.pending.size() != 0)
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    req_t r;
    stim_done = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: unit-cube style planes, then edge extremes
    for (int p = 0; p < NumPlanes; p++) begin
      logic [31:0] one;
      one = (p % 2) ? 32'hffff_0000 : 32'h0001_0000;
      send_beat(plane_load(p, p / 2 == 0 ? one : 0, p / 2 == 1 ? one : 0,
                           p / 2 == 2 ? one : 0, 32'h0001_0000));
    end
    r = plane_load(6, 32'h8000_0000, 0, 0, 0);  // slot out of range
    send_beat(r);
    r = plane_load(7, 32'h7fff_ffff, 0, 0, 0);
    send_beat(r);
    r.kind = req_e'(2'd3);  // unused kind, dropped
    send_beat(r);
    for (int t = 0; t < 8; t++) begin
      r.kind = t[0] ? REQ_PRISM : REQ_TRI;
      r.slot = 3'(t);
      for (int k = 0; k < 9; k++)
        case (t / 2)
          0: r.crd[k] = 0;                               // contained
          1: r.crd[k] = k == 0 ? 32'h0003_0000 : 0;      // intersects
          2: r.crd[k] = k % 3 == 0 ? 32'h0005_0000 : 0;  // all beyond x plane
          default: r.crd[k] = k % 2 ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
      r.crd[9] = t[1] ? 32'h0000_4000 : 32'h8000_0000;
      send_beat(r);
    end
    r = plane_load(0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_beat(r);
    r = plane_load(5, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(r);
    for (int t = 0; t < 4; t++) send_beat(rand_check());
    idle_bus();

    // hold off until the pipe drains once
    wait (board.pending.size() == 0);
    @(negedge clk_i);

    // random: mostly checks, with reloads of planes now and then, some sent as the dropped kind
    while (sent < 1000) begin
      if ($urandom_range(0, 9) == 0) begin
        r = plane_load($urandom_range(0, 7), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord());
        if ($urandom_range(0, 15) == 0) r.kind = req_e'(2'd3);
      end else begin
        r = rand_check();
      end
      send_beat(r);
    end
    idle_bus();
    stim_done = 1'b1;

    wait (board.pending.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("sent %0d beats (loads, triangle and prism checks, dropped kinds)", sent);
    $display("checked %0d verdict beats under random gaps and stalls", board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tfc_pkg.sv
design/triangle_frustum_classifier.sv
tb/sv/triangle_frustum_classifier_tb.sv
